FILE: src/gbn_pkg.sv
package gbn_pkg;

  localparam int SEQ_MAX       = 6;
  localparam int SEQ_W         = 3;
  localparam int MASK_W        = 7;
  localparam int PAYLOAD_BYTES = 256;
  localparam int LEN_W         = 9;
  localparam int BYTE_W        = 8;
  localparam int MIN_FRAME_LEN = 5;
  localparam int HDR_LEN       = 7;

  typedef enum logic [1:0] {
    FUNC_PKT = 2'd0,
    FUNC_PHY = 2'd1,
    FUNC_RX  = 2'd2,
    FUNC_TMO = 2'd3
  } func_e;

  typedef struct packed {
    logic start;     // item accepted this cycle
    logic ack_step;  // free the oldest outstanding frame
    logic ack_done;  // ack walk finished, post the frame-received result
    logic rs_step;   // post one resent frame
  } gbn_cmd_t;

  typedef struct packed {
    logic out_free;    // output register empty or being taken
    logic frame_good;  // incoming frame passes length and CRC
    logic cnt_zero;    // nothing outstanding
    logic win_hit;     // latched ack lies in [oldest, next_to_send)
    logic rs_last;     // one resend left
  } gbn_sts_t;

  function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] k);
    return (k == SEQ_W'(SEQ_MAX)) ? '0 : k + SEQ_W'(1);
  endfunction

endpackage

FILE: src/go_back_n_link_controller_core.sv
// channel | valid     | stall       | payload
// --------+-----------+-------------+------------------------------------------------
// in      | in_valid_i| in_stall_o  | func_i rx_crc_ok_i rx_is_data_i rx_seq_i
//         |           |             | rx_ack_i rx_len_i
// out     | out_valid_o| out_stall_i| send_valid_o send_seq_o send_ack_o
//         |           |             | deliver_valid_o deliver_len_o stop_mask_o
//         |           |             | net_enable_o last_o
//
// One item at a time. Packet-ready, physical-ready and bad frames post their
// result the cycle after acceptance. A good frame first runs the ack walk, which
// frees one outstanding frame per cycle, and posts its result when the walk ends.
// A timeout resends each outstanding frame, one per cycle while the output is free.
// Input stalls while an item is in work or the output register is held.
// Reset clears all window pointers, counts and the physical-ready flag.
module go_back_n_link_controller_core
  import gbn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic                rx_crc_ok_i,
  input  logic                rx_is_data_i,
  input  logic [BYTE_W-1:0]   rx_seq_i,
  input  logic [BYTE_W-1:0]   rx_ack_i,
  input  logic [LEN_W-1:0]    rx_len_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                send_valid_o,
  output logic [SEQ_W-1:0]    send_seq_o,
  output logic [SEQ_W-1:0]    send_ack_o,
  output logic                deliver_valid_o,
  output logic [LEN_W-1:0]    deliver_len_o,
  output logic [MASK_W-1:0]   stop_mask_o,
  output logic                net_enable_o,
  output logic                last_o
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  gbn_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .rx_crc_ok_i     (rx_crc_ok_i),
    .rx_is_data_i    (rx_is_data_i),
    .rx_seq_i        (rx_seq_i),
    .rx_ack_i        (rx_ack_i),
    .rx_len_i        (rx_len_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .send_valid_o    (send_valid_o),
    .send_seq_o      (send_seq_o),
    .send_ack_o      (send_ack_o),
    .deliver_valid_o (deliver_valid_o),
    .deliver_len_o   (deliver_len_o),
    .stop_mask_o     (stop_mask_o),
    .net_enable_o    (net_enable_o),
    .last_o          (last_o)
  );

endmodule

FILE: src/gbn_ctrl.sv
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     func_i,
  input  gbn_sts_t       sts_i,
  output logic           in_stall_o,
  output gbn_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_RESEND
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  func_e  func;

  assign func       = func_e'(func_i);
  assign in_stall_o = !(state_q == ST_IDLE && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          if (func == FUNC_RX && sts_i.frame_good) begin
            state_d = ST_ACK;
          end else if (func == FUNC_TMO && !sts_i.cnt_zero) begin
            state_d = ST_RESEND;
          end
        end
      end
      ST_ACK: begin
        if (sts_i.win_hit) begin
          cmd_o.ack_step = 1'b1;
        end else begin
          cmd_o.ack_done = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RESEND: begin
        if (sts_i.out_free) begin
          cmd_o.rs_step = 1'b1;
          if (sts_i.rs_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ack walk is bounded by the window size: one step per outstanding frame, then the done cycle
  a_ack_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_ACK) |-> ##[1:7] (state_q != ST_ACK))
    else $error("ack walk ran too long");

endmodule

FILE: src/gbn_dp.sv
module gbn_dp
  import gbn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbn_cmd_t            cmd_i,
  output gbn_sts_t            sts_o,
  input  logic [1:0]          func_i,
  input  logic                rx_crc_ok_i,
  input  logic                rx_is_data_i,
  input  logic [BYTE_W-1:0]   rx_seq_i,
  input  logic [BYTE_W-1:0]   rx_ack_i,
  input  logic [LEN_W-1:0]    rx_len_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                send_valid_o,
  output logic [SEQ_W-1:0]    send_seq_o,
  output logic [SEQ_W-1:0]    send_ack_o,
  output logic                deliver_valid_o,
  output logic [LEN_W-1:0]    deliver_len_o,
  output logic [MASK_W-1:0]   stop_mask_o,
  output logic                net_enable_o,
  output logic                last_o
);

  // link state
  logic [SEQ_W-1:0]  nts_q, nts_d;
  logic [SEQ_W-1:0]  old_q, old_d;
  logic [SEQ_W-1:0]  exp_q, exp_d;
  logic [SEQ_W-1:0]  cnt_q, cnt_d;
  logic              phy_q, phy_d;
  // per-event working registers
  logic [BYTE_W-1:0] rack_q, rack_d;
  logic              dv_q, dv_d;
  logic [LEN_W-1:0]  dl_q, dl_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [SEQ_W-1:0]  rs_left_q, rs_left_d;
  // output register
  logic              ov_q, ov_d;
  logic              o_sv_q, o_sv_d;
  logic [SEQ_W-1:0]  o_seq_q, o_seq_d;
  logic [SEQ_W-1:0]  o_ack_q, o_ack_d;
  logic              o_dv_q, o_dv_d;
  logic [LEN_W-1:0]  o_dl_q, o_dl_d;
  logic [MASK_W-1:0] o_mask_q, o_mask_d;
  logic              o_net_q, o_net_d;
  logic              o_last_q, o_last_d;

  logic              load;
  logic [SEQ_W-1:0]  ackval;
  logic              win_full;
  logic              net_now;
  logic              frame_good;
  logic              in_order;
  logic [LEN_W-1:0]  len_m7;
  logic [LEN_W-1:0]  len_clamp;
  logic [BYTE_W-1:0] a8, c8;
  func_e             func;

  assign func       = func_e'(func_i);
  assign ackval     = (exp_q == '0) ? SEQ_W'(SEQ_MAX) : exp_q - SEQ_W'(1);
  assign win_full   = (cnt_q >= SEQ_W'(SEQ_MAX));
  assign net_now    = !win_full && phy_q;
  assign frame_good = (rx_len_i >= LEN_W'(MIN_FRAME_LEN)) && rx_crc_ok_i;
  assign in_order   = rx_is_data_i && (rx_seq_i == BYTE_W'(exp_q));
  assign len_m7     = rx_len_i - LEN_W'(HDR_LEN);
  assign len_clamp  = (rx_len_i < LEN_W'(HDR_LEN)) ? '0 :
                      (len_m7 > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : len_m7;

  // cyclic window test, ack compared as a full byte
  assign a8 = BYTE_W'(old_q);
  assign c8 = BYTE_W'(nts_q);
  assign sts_o.win_hit = (a8 <= rack_q && rack_q < c8) ||
                         (c8 < a8 && a8 <= rack_q) ||
                         (rack_q < c8 && c8 < a8);
  assign sts_o.out_free   = !ov_q || !out_stall_i;
  assign sts_o.frame_good = frame_good;
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.rs_last    = (rs_left_q == SEQ_W'(1));

  always_comb begin
    nts_d     = nts_q;
    old_d     = old_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    phy_d     = phy_q;
    rack_d    = rack_q;
    dv_d      = dv_q;
    dl_d      = dl_q;
    mask_d    = mask_q;
    rs_left_d = rs_left_q;
    load      = 1'b0;
    o_sv_d    = 1'b0;
    o_seq_d   = '0;
    o_ack_d   = '0;
    o_dv_d    = 1'b0;
    o_dl_d    = '0;
    o_mask_d  = '0;
    o_net_d   = net_now;
    o_last_d  = 1'b1;

    if (cmd_i.start) begin
      case (func)
        FUNC_PKT: begin
          load    = 1'b1;
          o_net_d = 1'b0;
          if (!win_full) begin
            cnt_d   = cnt_q + SEQ_W'(1);
            phy_d   = 1'b0;
            nts_d   = seq_next(nts_q);
            o_sv_d  = 1'b1;
            o_seq_d = nts_q;
            o_ack_d = ackval;
          end
        end
        FUNC_PHY: begin
          load    = 1'b1;
          phy_d   = 1'b1;
          o_net_d = !win_full;
        end
        FUNC_RX: begin
          rack_d = rx_ack_i;
          mask_d = '0;
          dv_d   = 1'b0;
          dl_d   = '0;
          if (!frame_good) begin
            load = 1'b1;
          end else if (in_order) begin
            dv_d  = 1'b1;
            dl_d  = len_clamp;
            exp_d = seq_next(exp_q);
          end
        end
        default: begin
          nts_d     = old_q;
          rs_left_d = cnt_q;
          if (cnt_q == '0) begin
            load = 1'b1;
          end else begin
            phy_d = 1'b0;
          end
        end
      endcase
    end

    if (cmd_i.ack_step) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - SEQ_W'(1);
      end
      mask_d = mask_q | (MASK_W'(1) << old_q);
      old_d  = seq_next(old_q);
    end

    if (cmd_i.ack_done) begin
      load     = 1'b1;
      o_dv_d   = dv_q;
      o_dl_d   = dl_q;
      o_mask_d = mask_q;
    end

    if (cmd_i.rs_step) begin
      load      = 1'b1;
      o_sv_d    = 1'b1;
      o_seq_d   = nts_q;
      o_ack_d   = ackval;
      o_last_d  = (rs_left_q == SEQ_W'(1));
      nts_d     = seq_next(nts_q);
      rs_left_d = rs_left_q - SEQ_W'(1);
    end

    if (load) begin
      ov_d = 1'b1;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nts_q     <= '0;
      old_q     <= '0;
      exp_q     <= '0;
      cnt_q     <= '0;
      phy_q     <= 1'b0;
      rs_left_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      nts_q     <= nts_d;
      old_q     <= old_d;
      exp_q     <= exp_d;
      cnt_q     <= cnt_d;
      phy_q     <= phy_d;
      rs_left_q <= rs_left_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rack_q <= rack_d;
    dv_q   <= dv_d;
    dl_q   <= dl_d;
    mask_q <= mask_d;
    if (load) begin
      o_sv_q   <= o_sv_d;
      o_seq_q  <= o_seq_d;
      o_ack_q  <= o_ack_d;
      o_dv_q   <= o_dv_d;
      o_dl_q   <= o_dl_d;
      o_mask_q <= o_mask_d;
      o_net_q  <= o_net_d;
      o_last_q <= o_last_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign send_valid_o    = o_sv_q;
  assign send_seq_o      = o_seq_q;
  assign send_ack_o      = o_ack_q;
  assign deliver_valid_o = o_dv_q;
  assign deliver_len_o   = o_dl_q;
  assign stop_mask_o     = o_mask_q;
  assign net_enable_o    = o_net_q;
  assign last_o          = o_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SEQ_W'(SEQ_MAX))
    else $error("outstanding count beyond window");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ov_q) |-> !out_stall_i)
    else $error("output register overwritten while stalled");

  a_send_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_sv_q) |-> (!o_dv_q && o_mask_q == '0))
    else $error("send item carries delivery or stop bits");

endmodule
